@@ src/saws_pkg.sv @@
// ----------------------------------------------------------------------------
// saws_pkg
// Types and constants shared by the stop-and-wait sender.
// ----------------------------------------------------------------------------
package saws_pkg;

   localparam int unsigned MaxPayload     = 4096;
   localparam int unsigned LenWidth       = 13;
   localparam int unsigned NumWidth       = 32;
   localparam int unsigned TicksWidth     = 16;
   localparam int unsigned RetryWidth     = 4;
   localparam int unsigned CsrDataWidth   = 16;
   localparam int unsigned CsrAddrWidth   = 1;
   localparam int unsigned ReqDataWidth   = 80;
   localparam int unsigned RspDataWidth   = 88;

   localparam logic [TicksWidth-1:0] TimeoutReset = 16'd5000;
   localparam logic [RetryWidth-1:0] RetriesReset = 4'd5;

   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_TIMEOUT_TICKS = 1'b0,
      CSR_MAX_RETRIES   = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_CONNECT = 3'd0,
      OP_RX      = 3'd1,
      OP_TICK    = 3'd2,
      OP_CHUNK   = 3'd3,
      OP_CLOSE   = 3'd4
   } opcode_type;

   typedef enum logic [2:0] {
      PKT_DATA    = 3'd0,
      PKT_SYN     = 3'd1,
      PKT_SYN_ACK = 3'd2,
      PKT_ACK     = 3'd3,
      PKT_FIN     = 3'd4,
      PKT_FIN_ACK = 3'd5
   } pkt_type;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_SYN_WAIT  = 3'd1,
      PH_CONNECTED = 3'd2,
      PH_WAIT_ACK  = 3'd3,
      PH_FIN_WAIT  = 3'd4,
      PH_CLOSED    = 3'd5
   } phase_type;

   typedef enum logic [3:0] {
      ST_NONE         = 4'd0,
      ST_CONNECTED    = 4'd1,
      ST_SENT         = 4'd2,
      ST_ACKED        = 4'd3,
      ST_RETRY        = 4'd4,
      ST_GAVE_UP      = 4'd5,
      ST_DONE         = 4'd6,
      ST_CLOSED       = 4'd7,
      ST_CONNECT_FAIL = 4'd8,
      ST_CLOSE_FAIL   = 4'd9,
      ST_IGNORED      = 4'd10
   } status_type;

   // Result item, first field in the highest bits once packed.
   typedef struct packed {
      status_type          status;
      logic [LenWidth-1:0] send_len;
      logic [NumWidth-1:0] send_ack;
      logic [NumWidth-1:0] send_seq;
      logic [2:0]          send_type;
      logic                send_valid;
   } result_type;

endpackage

@@ src/stop_and_wait_sender.sv @@
// ----------------------------------------------------------------------------
// stop_and_wait_sender
// Sender side of a stop-and-wait reliable-datagram link.
// ----------------------------------------------------------------------------
// Every request (connect, received packet, tick, new chunk, close) produces
// exactly one response, registered into the output register or, while the
// response side is stalled, into the skid entry; a request can be accepted in
// every cycle. The link state is updated by a single pass of compares and
// increments at the request edge; the response sits in an output register
// backed by one skid entry, so requests keep flowing while one response waits
// and req_tready drops only when both entries are full.
// Configuration writes take effect at the next edge and are meant for idle.

module stop_and_wait_sender (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // rx_type[2:0], rx_seq[34:3], rx_ack[66:35], chunk_len[79:67]
   input  logic [saws_pkg::ReqDataWidth-1:0]     req_tdata,
   // opcode[2:0]
   input  logic [2:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // send_valid[0], send_type[3:1], send_seq[35:4], send_ack[67:36],
   // send_len[80:68], status[84:81], zero fill above
   output logic [saws_pkg::RspDataWidth-1:0]     rsp_tdata,
   input  logic                                  csr_we,
   input  logic [saws_pkg::CsrAddrWidth-1:0]     csr_addr,
   input  logic [saws_pkg::CsrDataWidth-1:0]     csr_wdata
);

   localparam int unsigned NW = saws_pkg::NumWidth;
   localparam int unsigned LW = saws_pkg::LenWidth;
   localparam int unsigned TW = saws_pkg::TicksWidth;
   localparam int unsigned RW = saws_pkg::RetryWidth;

   // Configuration registers.
   logic [TW-1:0] timeout_ff;
   logic [RW-1:0] retries_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= saws_pkg::TimeoutReset;
         retries_ff <= saws_pkg::RetriesReset;
      end else if (csr_we) begin
         unique case (saws_pkg::csr_index_type'(csr_addr))
            saws_pkg::CSR_TIMEOUT_TICKS: timeout_ff <= csr_wdata[TW-1:0];
            saws_pkg::CSR_MAX_RETRIES:   retries_ff <= csr_wdata[RW-1:0];
            default: ;
         endcase
      end
   end

   // Request fields.
   logic [2:0]    rx_type;
   logic [NW-1:0] rx_seq;
   logic [NW-1:0] rx_ack;
   logic [LW-1:0] chunk_len;
   logic [2:0]    opcode;

   assign rx_type   = req_tdata[2:0];
   assign rx_seq    = req_tdata[3 +: NW];
   assign rx_ack    = req_tdata[3+NW +: NW];
   assign chunk_len = req_tdata[3+2*NW +: LW];
   assign opcode    = req_tuser;

   // Link state.
   saws_pkg::phase_type phase_ff, phase_in;
   logic [NW-1:0] seq_ff, seq_in;
   logic [NW-1:0] ackval_ff, ackval_in;
   logic [RW-1:0] retry_ff, retry_in;
   logic [TW-1:0] tick_ff, tick_in;
   logic [LW-1:0] plen_ff, plen_in;
   logic          final_ff, final_in;

   saws_pkg::result_type result;
   logic [NW-1:0] seq_next;
   logic [RW-1:0] retry_sat;
   logic [TW-1:0] tick_sat;
   logic          req_fire;

   assign req_fire  = req_tvalid && req_tready;
   assign seq_next  = seq_ff + 1'b1;
   assign retry_sat = (retry_ff == {RW{1'b1}}) ? retry_ff : retry_ff + 1'b1;
   assign tick_sat  = (tick_ff == {TW{1'b1}}) ? tick_ff : tick_ff + 1'b1;

   always_comb begin
      phase_in  = phase_ff;
      seq_in    = seq_ff;
      ackval_in = ackval_ff;
      retry_in  = retry_ff;
      tick_in   = tick_ff;
      plen_in   = plen_ff;
      final_in  = final_ff;

      result            = '0;
      result.status     = saws_pkg::ST_IGNORED;

      priority if (opcode == saws_pkg::OP_CONNECT &&
                   (phase_ff == saws_pkg::PH_IDLE || phase_ff == saws_pkg::PH_CLOSED)) begin
         phase_in          = saws_pkg::PH_SYN_WAIT;
         result.send_valid = 1'b1;
         result.send_type  = saws_pkg::PKT_SYN;
         result.send_seq   = seq_ff;
         result.send_ack   = ackval_ff;
         result.status     = saws_pkg::ST_SENT;
      end else if (opcode == saws_pkg::OP_RX && phase_ff == saws_pkg::PH_SYN_WAIT) begin
         if (rx_type == saws_pkg::PKT_SYN_ACK && rx_ack == seq_next) begin
            ackval_in         = rx_seq + 1'b1;
            phase_in          = saws_pkg::PH_CONNECTED;
            result.send_valid = 1'b1;
            result.send_type  = saws_pkg::PKT_ACK;
            result.send_seq   = rx_ack;
            result.send_ack   = rx_seq + 1'b1;
            result.status     = saws_pkg::ST_CONNECTED;
         end else begin
            phase_in      = saws_pkg::PH_IDLE;
            result.status = saws_pkg::ST_CONNECT_FAIL;
         end
      end else if (opcode == saws_pkg::OP_CHUNK && phase_ff == saws_pkg::PH_CONNECTED) begin
         plen_in = (chunk_len > LW'(saws_pkg::MaxPayload)) ?
                   LW'(saws_pkg::MaxPayload) : chunk_len;
         final_in          = (chunk_len == '0);
         retry_in          = '0;
         tick_in           = '0;
         phase_in          = saws_pkg::PH_WAIT_ACK;
         result.send_valid = 1'b1;
         result.send_type  = saws_pkg::PKT_DATA;
         result.send_seq   = seq_ff;
         result.send_ack   = ackval_ff;
         result.send_len   = plen_in;
         result.status     = saws_pkg::ST_SENT;
      end else if ((opcode == saws_pkg::OP_RX || opcode == saws_pkg::OP_TICK) &&
                   phase_ff == saws_pkg::PH_WAIT_ACK) begin
         if (opcode == saws_pkg::OP_RX && rx_type == saws_pkg::PKT_ACK &&
             rx_ack == seq_next) begin
            seq_in        = seq_next;
            phase_in      = saws_pkg::PH_CONNECTED;
            tick_in       = '0;
            result.status = final_ff ? saws_pkg::ST_DONE : saws_pkg::ST_ACKED;
         end else if (opcode == saws_pkg::OP_TICK && tick_sat < timeout_ff) begin
            tick_in       = tick_sat;
            result.status = saws_pkg::ST_NONE;
         end else begin
            // A wrong packet or a timeout costs one attempt.
            retry_in = retry_sat;
            tick_in  = '0;
            if (retry_sat >= retries_ff) begin
               phase_in      = saws_pkg::PH_CONNECTED;
               result.status = saws_pkg::ST_GAVE_UP;
            end else begin
               result.send_valid = 1'b1;
               result.send_type  = saws_pkg::PKT_DATA;
               result.send_seq   = seq_ff;
               result.send_ack   = ackval_ff;
               result.send_len   = plen_ff;
               result.status     = saws_pkg::ST_RETRY;
            end
         end
      end else if (opcode == saws_pkg::OP_TICK) begin
         result.status = saws_pkg::ST_NONE;
      end else if (opcode == saws_pkg::OP_CLOSE && phase_ff == saws_pkg::PH_CONNECTED) begin
         ackval_in         = seq_ff;
         phase_in          = saws_pkg::PH_FIN_WAIT;
         result.send_valid = 1'b1;
         result.send_type  = saws_pkg::PKT_FIN;
         result.send_seq   = seq_ff;
         result.send_ack   = seq_ff;
         result.status     = saws_pkg::ST_SENT;
      end else if (opcode == saws_pkg::OP_RX && phase_ff == saws_pkg::PH_FIN_WAIT) begin
         phase_in = saws_pkg::PH_CLOSED;
         if (rx_type == saws_pkg::PKT_FIN_ACK) begin
            ackval_in         = rx_seq + 1'b1;
            result.send_valid = 1'b1;
            result.send_type  = saws_pkg::PKT_ACK;
            result.send_seq   = rx_ack;
            result.send_ack   = rx_seq + 1'b1;
            result.status     = saws_pkg::ST_CLOSED;
         end else begin
            result.status = saws_pkg::ST_CLOSE_FAIL;
         end
      end else begin
         result.status = saws_pkg::ST_IGNORED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= saws_pkg::PH_IDLE;
         seq_ff    <= '0;
         ackval_ff <= '0;
         retry_ff  <= '0;
         tick_ff   <= '0;
         plen_ff   <= '0;
         final_ff  <= 1'b0;
      end else if (req_fire) begin
         phase_ff  <= phase_in;
         seq_ff    <= seq_in;
         ackval_ff <= ackval_in;
         retry_ff  <= retry_in;
         tick_ff   <= tick_in;
         plen_ff   <= plen_in;
         final_ff  <= final_in;
      end
   end

   // Output register with one skid entry behind it.
   saws_pkg::result_type out_ff, skid_ff;
   logic out_valid_ff, out_valid_in;
   logic skid_valid_ff, skid_valid_in;
   logic out_free;

   assign req_tready = !skid_valid_ff;
   assign out_free   = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         out_valid_in  = skid_valid_ff || req_fire;
         skid_valid_in = 1'b0;
      end else if (req_fire) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (req_fire) begin
            out_ff <= result;
         end
      end else if (req_fire) begin
         skid_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(saws_pkg::RspDataWidth - $bits(saws_pkg::result_type)){1'b0}},
                        out_ff};

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the stop-and-wait sender. A mirror of the link
// state predicts the response header for every accepted request. A checker
// compares each response with the oldest prediction. Directed tests walk the
// connect, transfer, retry and close paths. Random traffic then runs under
// several register settings, with gaps and back-pressure on both streams.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ResetCycles   = 11;
   localparam int unsigned DrainCycles   = 4;
   localparam int unsigned WatchdogLimit = 1000;
   localparam int unsigned RandomItems   = 1300;
   localparam int unsigned NumSettings   = 6;
   localparam int unsigned LastOpcode    = 7;
   localparam int unsigned LastPktCode   = 7;
   localparam int unsigned MaxLenCode    = 8191;
   localparam int unsigned ResultBits    = $bits(saws_pkg::result_type);
   localparam int unsigned NW            = saws_pkg::NumWidth;
   localparam int unsigned LW            = saws_pkg::LenWidth;
   localparam int unsigned TW            = saws_pkg::TicksWidth;
   localparam int unsigned RW            = saws_pkg::RetryWidth;
   localparam int unsigned MaxPayload    = saws_pkg::MaxPayload;

   logic                                clock;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [saws_pkg::ReqDataWidth-1:0]   req_tdata  = '0;
   logic [2:0]                          req_tuser  = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [saws_pkg::RspDataWidth-1:0]   rsp_tdata;
   logic                                csr_we     = 1'b0;
   logic [saws_pkg::CsrAddrWidth-1:0]   csr_addr   = '0;
   logic [saws_pkg::CsrDataWidth-1:0]   csr_wdata  = '0;

   stop_and_wait_sender dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Mirror of the sender state and its registers.
   saws_pkg::phase_type link_phase;
   logic [NW-1:0]       seq_num;
   logic [NW-1:0]       ack_field;
   logic [RW-1:0]       attempts;
   logic [TW-1:0]       ticks_waited;
   logic [LW-1:0]       chunk_pending;
   logic                chunk_is_final;
   logic [TW-1:0]       timeout_setting;
   logic [RW-1:0]       retry_setting;

   saws_pkg::result_type pending_headers[$];
   int unsigned errors      = 0;
   int unsigned requests    = 0;
   int unsigned settings    = 0;
   int unsigned chunks_done = 0;
   int unsigned idle_cycles = 0;
   int unsigned stall_left  = 0;
   bit          idling_on   = 1'b1;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!idling_on || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic saws_pkg::result_type packet_header(logic [2:0] kind,
         logic [NW-1:0] sq, logic [NW-1:0] ak, logic [LW-1:0] len,
         saws_pkg::status_type st);
      saws_pkg::result_type h;
      h.send_valid = 1'b1;
      h.send_type  = kind;
      h.send_seq   = sq;
      h.send_ack   = ak;
      h.send_len   = len;
      h.status     = st;
      return h;
   endfunction

   // A lost attempt: resend the chunk, or give up once the attempts run out.
   function automatic saws_pkg::result_type resend_or_give_up();
      saws_pkg::result_type h;
      h = '0;
      if (attempts < 4'd15) attempts = attempts + 1'b1;
      ticks_waited = '0;
      if (attempts >= retry_setting) begin
         link_phase = saws_pkg::PH_CONNECTED;
         h.status   = saws_pkg::ST_GAVE_UP;
      end else begin
         h = packet_header(saws_pkg::PKT_DATA, seq_num, ack_field, chunk_pending,
                           saws_pkg::ST_RETRY);
      end
      return h;
   endfunction

   function automatic saws_pkg::result_type sender_response(logic [2:0] op,
         logic [2:0] rtype, logic [NW-1:0] rseq, logic [NW-1:0] rack,
         logic [LW-1:0] clen);
      saws_pkg::result_type h;
      logic [NW-1:0]        next_seq;
      h        = '0;
      h.status = saws_pkg::ST_IGNORED;
      next_seq = seq_num + 1'b1;
      if (op == saws_pkg::OP_CONNECT &&
          (link_phase == saws_pkg::PH_IDLE || link_phase == saws_pkg::PH_CLOSED)) begin
         link_phase = saws_pkg::PH_SYN_WAIT;
         h = packet_header(saws_pkg::PKT_SYN, seq_num, ack_field, '0, saws_pkg::ST_SENT);
      end else if (op == saws_pkg::OP_RX && link_phase == saws_pkg::PH_SYN_WAIT) begin
         if (rtype == saws_pkg::PKT_SYN_ACK && rack == next_seq) begin
            ack_field  = rseq + 1'b1;
            link_phase = saws_pkg::PH_CONNECTED;
            h = packet_header(saws_pkg::PKT_ACK, rack, ack_field, '0,
                              saws_pkg::ST_CONNECTED);
         end else begin
            link_phase = saws_pkg::PH_IDLE;
            h.status   = saws_pkg::ST_CONNECT_FAIL;
         end
      end else if (op == saws_pkg::OP_CHUNK && link_phase == saws_pkg::PH_CONNECTED) begin
         chunk_pending  = (clen > MaxPayload) ? LW'(MaxPayload) : clen;
         chunk_is_final = (clen == '0);
         attempts       = '0;
         ticks_waited   = '0;
         link_phase     = saws_pkg::PH_WAIT_ACK;
         h = packet_header(saws_pkg::PKT_DATA, seq_num, ack_field, chunk_pending,
                           saws_pkg::ST_SENT);
      end else if (op == saws_pkg::OP_RX && link_phase == saws_pkg::PH_WAIT_ACK) begin
         if (rtype == saws_pkg::PKT_ACK && rack == next_seq) begin
            seq_num      = next_seq;
            link_phase   = saws_pkg::PH_CONNECTED;
            ticks_waited = '0;
            h.status     = chunk_is_final ? saws_pkg::ST_DONE : saws_pkg::ST_ACKED;
         end else begin
            h = resend_or_give_up();
         end
      end else if (op == saws_pkg::OP_TICK && link_phase == saws_pkg::PH_WAIT_ACK) begin
         if (ticks_waited < 16'hFFFF) ticks_waited = ticks_waited + 1'b1;
         if (ticks_waited >= timeout_setting) h = resend_or_give_up();
         else h.status = saws_pkg::ST_NONE;
      end else if (op == saws_pkg::OP_TICK) begin
         h.status = saws_pkg::ST_NONE;
      end else if (op == saws_pkg::OP_CLOSE && link_phase == saws_pkg::PH_CONNECTED) begin
         ack_field  = seq_num;
         link_phase = saws_pkg::PH_FIN_WAIT;
         h = packet_header(saws_pkg::PKT_FIN, seq_num, seq_num, '0, saws_pkg::ST_SENT);
      end else if (op == saws_pkg::OP_RX && link_phase == saws_pkg::PH_FIN_WAIT) begin
         link_phase = saws_pkg::PH_CLOSED;
         if (rtype == saws_pkg::PKT_FIN_ACK) begin
            ack_field = rseq + 1'b1;
            h = packet_header(saws_pkg::PKT_ACK, rack, ack_field, '0, saws_pkg::ST_CLOSED);
         end else begin
            h.status = saws_pkg::ST_CLOSE_FAIL;
         end
      end
      return h;
   endfunction

   // Sends one request and records the header it should produce.
   task automatic send_request(logic [2:0] op, logic [2:0] rtype, logic [NW-1:0] rseq,
         logic [NW-1:0] rack, logic [LW-1:0] clen);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {clen, rack, rseq, rtype};
      do @(posedge clock); while (!req_tready);
      pending_headers.push_back(sender_response(op, rtype, rseq, rack, clen));
      requests++;
   endtask

   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (pending_headers.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Writes both registers on back-to-back edges while the sender is idle.
   task automatic write_settings(logic [TW-1:0] timeout, logic [RW-1:0] retries);
      wait_for_idle();
      csr_we    <= 1'b1;
      csr_addr  <= saws_pkg::CSR_TIMEOUT_TICKS;
      csr_wdata <= timeout;
      @(posedge clock);
      csr_addr  <= saws_pkg::CSR_MAX_RETRIES;
      csr_wdata <= saws_pkg::CsrDataWidth'(retries);
      @(posedge clock);
      csr_we <= 1'b0;
      timeout_setting = timeout;
      retry_setting   = retries;
      settings++;
   endtask

   task automatic check_field(string name, logic [NW-1:0] expected,
         logic [NW-1:0] actual);
      if (expected !== actual) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, expected,
            actual);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      saws_pkg::result_type exp_hdr;
      saws_pkg::result_type got_hdr;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_hdr = saws_pkg::result_type'(rsp_tdata[ResultBits-1:0]);
         if (pending_headers.size() == 0) begin
            $display("%0t ns: response with no request pending, expected none, actual %0h",
               $time, rsp_tdata);
            errors++;
         end else begin
            exp_hdr = pending_headers.pop_front();
            check_field("send_valid", 32'(exp_hdr.send_valid), 32'(got_hdr.send_valid));
            check_field("send_type", 32'(exp_hdr.send_type), 32'(got_hdr.send_type));
            check_field("send_seq", exp_hdr.send_seq, got_hdr.send_seq);
            check_field("send_ack", exp_hdr.send_ack, got_hdr.send_ack);
            check_field("send_len", 32'(exp_hdr.send_len), 32'(got_hdr.send_len));
            check_field("status", 32'(exp_hdr.status), 32'(got_hdr.status));
            check_field("zero fill", '0,
               32'(rsp_tdata[saws_pkg::RspDataWidth-1:ResultBits]));
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         stall_left <= pick_gap();
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("%0t ns: no request or response moved for %0d cycles", $time, idle_cycles);
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic test_connection_flow();
      send_request(saws_pkg::OP_CLOSE, saws_pkg::PKT_DATA, '0, '0, '0);
      send_request(3'(LastOpcode), 3'(LastPktCode), '1, '1, '1);
      send_request(saws_pkg::OP_TICK, saws_pkg::PKT_DATA, '0, '0, '0);
      send_request(saws_pkg::OP_CONNECT, saws_pkg::PKT_DATA, '0, '0, '0);
      send_request(saws_pkg::OP_CONNECT, saws_pkg::PKT_DATA, '0, '0, '0);
      // A SYN_ACK with the wrong ack number drops the link back to idle.
      send_request(saws_pkg::OP_RX, saws_pkg::PKT_SYN_ACK, 32'h1234_5678, seq_num + 2, '0);
      send_request(saws_pkg::OP_CONNECT, saws_pkg::PKT_DATA, '0, '0, '0);
      // The peer sequence wraps, so the ack field becomes zero.
      send_request(saws_pkg::OP_RX, saws_pkg::PKT_SYN_ACK, '1, seq_num + 1, '0);
      send_request(saws_pkg::OP_CHUNK, saws_pkg::PKT_DATA, '0, '0, LW'(MaxLenCode));
      send_request(saws_pkg::OP_TICK, saws_pkg::PKT_DATA, '0, '0, '0);
      send_request(saws_pkg::OP_RX, saws_pkg::PKT_DATA, '0, seq_num + 1, '0);
      send_request(saws_pkg::OP_RX, saws_pkg::PKT_ACK, '0, seq_num + 1, '0);
      send_request(saws_pkg::OP_CHUNK, saws_pkg::PKT_DATA, '0, '0, LW'(MaxPayload));
      send_request(saws_pkg::OP_RX, saws_pkg::PKT_ACK, '1, seq_num + 1, '0);
      send_request(saws_pkg::OP_CHUNK, saws_pkg::PKT_DATA, '0, '0, '0);
      send_request(saws_pkg::OP_RX, saws_pkg::PKT_ACK, '0, seq_num + 1, '0);
      send_request(saws_pkg::OP_CLOSE, saws_pkg::PKT_DATA, '0, '0, '0);
      send_request(saws_pkg::OP_RX, saws_pkg::PKT_FIN_ACK, $urandom, $urandom, '0);
   endtask

   task automatic test_retry_and_give_up();
      write_settings(16'd1, 4'd2);
      send_request(saws_pkg::OP_CONNECT, saws_pkg::PKT_DATA, '0, '0, '0);
      send_request(saws_pkg::OP_RX, saws_pkg::PKT_SYN_ACK, $urandom, seq_num + 1, '0);
      send_request(saws_pkg::OP_CHUNK, saws_pkg::PKT_DATA, '0, '0, 13'd100);
      send_request(saws_pkg::OP_TICK, saws_pkg::PKT_DATA, '0, '0, '0);
      send_request(saws_pkg::OP_TICK, saws_pkg::PKT_DATA, '0, '0, '0);
      // A final chunk that runs out of attempts reports gave_up, not done.
      send_request(saws_pkg::OP_CHUNK, saws_pkg::PKT_DATA, '0, '0, '0);
      send_request(saws_pkg::OP_RX, saws_pkg::PKT_FIN, '0, seq_num + 1, '0);
      send_request(saws_pkg::OP_RX, saws_pkg::PKT_ACK, '0, seq_num, '0);
      send_request(saws_pkg::OP_CLOSE, saws_pkg::PKT_DATA, '0, '0, '0);
      send_request(saws_pkg::OP_RX, saws_pkg::PKT_DATA, '0, '0, '0);
      send_request(saws_pkg::OP_RX, saws_pkg::PKT_ACK, '0, '0, '0);
      send_request(saws_pkg::OP_TICK, saws_pkg::PKT_DATA, '0, '0, '0);
   endtask

   task automatic test_register_extremes();
      // With both registers at zero the first tick ends the chunk.
      write_settings('0, '0);
      send_request(saws_pkg::OP_CONNECT, saws_pkg::PKT_DATA, '0, '0, '0);
      send_request(saws_pkg::OP_RX, saws_pkg::PKT_SYN_ACK, $urandom, seq_num + 1, '0);
      send_request(saws_pkg::OP_CHUNK, saws_pkg::PKT_DATA, '0, '0, 13'd5);
      send_request(saws_pkg::OP_TICK, saws_pkg::PKT_DATA, '0, '0, '0);
      write_settings('1, 4'd15);
      send_request(saws_pkg::OP_CHUNK, saws_pkg::PKT_DATA, '0, '0, 13'd1);
      repeat (3) send_request(saws_pkg::OP_TICK, saws_pkg::PKT_DATA, '0, '0, '0);
      send_request(saws_pkg::OP_RX, saws_pkg::PKT_ACK, '0, seq_num + 2, '0);
      send_request(saws_pkg::OP_RX, saws_pkg::PKT_ACK, '0, seq_num + 1, '0);
      send_request(saws_pkg::OP_CLOSE, saws_pkg::PKT_DATA, '0, '0, '0);
      send_request(saws_pkg::OP_RX, saws_pkg::PKT_FIN_ACK, '0, '1, '0);
   endtask

   function automatic logic [LW-1:0] pick_chunk_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return LW'($urandom_range(MaxPayload + 1, MaxLenCode));
      if (r < 25) return LW'(MaxPayload);
      return LW'($urandom_range(1, MaxPayload));
   endfunction

   // Mostly requests that fit the current phase, with random content.
   task automatic send_random_request();
      int unsigned   r;
      logic [2:0]    op;
      logic [2:0]    rtype;
      logic [NW-1:0] rseq;
      logic [NW-1:0] rack;
      logic [LW-1:0] clen;
      r     = $urandom_range(0, 99);
      op    = 3'($urandom_range(0, LastOpcode));
      rtype = 3'($urandom_range(0, LastPktCode));
      rseq  = $urandom;
      rack  = $urandom;
      clen  = LW'($urandom_range(0, MaxLenCode));
      if (r >= 10) begin
         r = $urandom_range(0, 99);
         unique case (link_phase)
            saws_pkg::PH_IDLE, saws_pkg::PH_CLOSED: begin
               op = saws_pkg::OP_CONNECT;
            end
            saws_pkg::PH_SYN_WAIT: begin
               op = saws_pkg::OP_RX;
               if (r < 85) begin
                  rtype = saws_pkg::PKT_SYN_ACK;
                  rack  = seq_num + 1;
               end
            end
            saws_pkg::PH_CONNECTED: begin
               op   = (r < 80) ? saws_pkg::OP_CHUNK : saws_pkg::OP_CLOSE;
               clen = pick_chunk_len();
            end
            saws_pkg::PH_WAIT_ACK: begin
               if (r < 45) begin
                  op    = saws_pkg::OP_RX;
                  rtype = saws_pkg::PKT_ACK;
                  rack  = seq_num + 1;
               end else if (r < 75) begin
                  op = saws_pkg::OP_TICK;
               end else if (r < 87) begin
                  op    = saws_pkg::OP_RX;
                  rtype = saws_pkg::PKT_ACK;
                  rack  = (seq_num + 1) ^ (32'd1 << $urandom_range(0, NW - 1));
               end else begin
                  op   = saws_pkg::OP_RX;
                  rack = seq_num + 1;
               end
            end
            default: begin
               op = saws_pkg::OP_RX;
               if (r < 85) rtype = saws_pkg::PKT_FIN_ACK;
            end
         endcase
      end
      send_request(op, rtype, rseq, rack, clen);
   endtask

   task automatic test_random_traffic();
      logic [TW-1:0] timeouts[NumSettings];
      logic [RW-1:0] retries[NumSettings];
      int unsigned   counted;
      timeouts = '{16'd1, 16'd2, 16'd6, 16'd0, 16'hFFFF, 16'($urandom_range(1, 8))};
      retries  = '{4'd1, 4'd4, 4'd15, 4'd0, 4'd15, 4'($urandom_range(1, 15))};
      for (int unsigned s = 0; s < NumSettings; s++) begin
         write_settings(timeouts[s], retries[s]);
         idling_on = (s != 2);
         counted   = 0;
         while (counted < RandomItems / NumSettings) begin
            send_random_request();
            if (pending_headers[$].status != saws_pkg::ST_IGNORED) counted++;
            if (pending_headers[$].status inside {saws_pkg::ST_ACKED, saws_pkg::ST_DONE})
               chunks_done++;
         end
      end
      idling_on = 1'b1;
   endtask

   initial begin
      link_phase      = saws_pkg::PH_IDLE;
      seq_num         = '0;
      ack_field       = '0;
      attempts        = '0;
      ticks_waited    = '0;
      chunk_pending   = '0;
      chunk_is_final  = 1'b0;
      timeout_setting = saws_pkg::TimeoutReset;
      retry_setting   = saws_pkg::RetriesReset;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_connection_flow();
      test_retry_and_give_up();
      test_register_extremes();
      test_random_traffic();
      wait_for_idle();
      $display("Sent %0d requests under %0d register settings; %0d chunks were acknowledged.",
         requests, settings, chunks_done);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches found", errors);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
